// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// general property, sampled on clk, off while rst is high
`define SCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same-cycle implication
`define SCT_ASSERT_IMP(lbl, cond, conseq, msg) \
  `SCT_ASSERT(lbl, (cond) |-> (conseq), msg)

`endif

// ===== rtl/core/sct_pkg.sv =====
// ---------------------------------------------------------------------------
// sct_pkg
// types, codes and character constants of the source character tokenizer
// ---------------------------------------------------------------------------
package sct_pkg;

  localparam int PosWidth  = 16;
  localparam int FifoDepth = 4;

  localparam logic [PosWidth-1:0] PosMax = {PosWidth{1'b1}};

  typedef enum logic [2:0] {
    ModeIdle  = 3'd0,
    ModeNum   = 3'd1,
    ModeIdent = 3'd2,
    ModeStr   = 3'd3,
    ModeEsc   = 3'd4,
    ModeColon = 3'd5,
    ModeHalt  = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    EvText  = 2'd0,
    EvDone  = 2'd1,
    EvError = 2'd2
  } event_kind_t;

  typedef enum logic [3:0] {
    TkId     = 4'd0,
    TkStr    = 4'd1,
    TkNat    = 4'd2,
    TkPlus   = 4'd3,
    TkSemi   = 4'd4,
    TkDcolon = 4'd5,
    TkColon  = 4'd6,
    TkLpar   = 4'd7,
    TkRpar   = 4'd8,
    TkLbrace = 4'd9,
    TkRbrace = 4'd10,
    TkComma  = 4'd11
  } token_kind_t;

  localparam logic OpChar = 1'b0;
  localparam logic OpEnd  = 1'b1;

  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChVt     = 8'h0B;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChLpar   = 8'h28;
  localparam logic [7:0] ChRpar   = 8'h29;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5A;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowZ   = 8'h7A;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;

  typedef struct packed {
    logic       operation;
    logic [7:0] char_code;
  } char_item_t;

  typedef struct packed {
    logic [1:0]          event_kind;
    logic [3:0]          token_kind;
    logic [7:0]          text_char;
    logic [PosWidth-1:0] line_number;
    logic [PosWidth-1:0] column_number;
    logic                last;
  } evt_item_t;

  // events caused by one item, in order
  typedef struct packed {
    logic [1:0] count;
    evt_item_t  first;
    evt_item_t  second;
  } step_res_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= ChLowA) && (c <= ChLowZ)) || ((c >= ChUpA) && (c <= ChUpZ))
           || (c == ChUnder);
  endfunction

  function automatic logic [PosWidth-1:0] sat_inc(logic [PosWidth-1:0] v);
    return (v == PosMax) ? v : v + 1'b1;
  endfunction

  function automatic evt_item_t make_evt(event_kind_t ev, token_kind_t tk,
                                         logic [7:0] ch, logic [PosWidth-1:0] row,
                                         logic [PosWidth-1:0] col);
    evt_item_t e;
    e.event_kind    = ev;
    e.token_kind    = tk;
    e.text_char     = ch;
    e.line_number   = row;
    e.column_number = col;
    e.last          = 1'b0;
    return e;
  endfunction

endpackage

// ===== rtl/core/sct_step.sv =====
// ---------------------------------------------------------------------------
// sct_step
// one lexer step: mode, row and column update and up to two events
// ---------------------------------------------------------------------------
module sct_step
  import sct_pkg::*;
(
  input  char_item_t          item,
  input  mode_t               mode,
  input  logic [PosWidth-1:0] row,
  input  logic [PosWidth-1:0] col,
  output mode_t               mode_next,
  output logic [PosWidth-1:0] row_next,
  output logic [PosWidth-1:0] col_next,
  output step_res_t           res
);

  logic [7:0]          c;
  logic [PosWidth-1:0] col_inc;
  logic                single_ok;
  token_kind_t         single_tk;

  logic                idle_emit;
  evt_item_t           idle_ev;
  mode_t               idle_mode;
  logic [PosWidth-1:0] idle_row;
  logic [PosWidth-1:0] idle_col;

  logic                own_emit;
  evt_item_t           own_ev;
  logic                use_idle;
  logic                second_ok;

  assign c       = item.char_code;
  assign col_inc = sat_inc(col);

  always_comb begin
    single_ok = 1'b1;
    single_tk = TkPlus;
    case (c)
      ChPlus:   single_tk = TkPlus;
      ChSemi:   single_tk = TkSemi;
      ChComma:  single_tk = TkComma;
      ChLpar:   single_tk = TkLpar;
      ChRpar:   single_tk = TkRpar;
      ChLbrace: single_tk = TkLbrace;
      ChRbrace: single_tk = TkRbrace;
      default:  single_ok = 1'b0;
    endcase
  end

  // character seen by an idle lexer, position not yet moved this item
  always_comb begin
    idle_emit = 1'b0;
    idle_ev   = make_evt(EvText, TkId, 8'h00, row, col);
    idle_mode = ModeIdle;
    idle_row  = row;
    idle_col  = col;
    if (c == ChSpace || c == ChCr || c == ChTab || c == ChVt) begin
      idle_col = col_inc;
    end else if (c == ChLf) begin
      idle_row = sat_inc(row);
      idle_col = '0;
    end else if (is_digit(c)) begin
      idle_emit = 1'b1;
      idle_ev   = make_evt(EvText, TkNat, c, row, col);
      idle_col  = col_inc;
      idle_mode = ModeNum;
    end else if (is_alpha(c)) begin
      idle_emit = 1'b1;
      idle_ev   = make_evt(EvText, TkId, c, row, col);
      idle_col  = col_inc;
      idle_mode = ModeIdent;
    end else if (c == ChQuote) begin
      idle_col  = col_inc;
      idle_mode = ModeStr;
    end else if (c == ChColon) begin
      idle_col  = col_inc;
      idle_mode = ModeColon;
    end else if (single_ok) begin
      idle_emit = 1'b1;
      idle_ev   = make_evt(EvDone, single_tk, 8'h00, row, col);
      idle_col  = col_inc;
    end else begin
      idle_emit = 1'b1;
      idle_ev   = make_evt(EvError, TkId, c, row, col);
      idle_mode = ModeHalt;
    end
  end

  always_comb begin
    own_emit  = 1'b0;
    own_ev    = make_evt(EvDone, TkId, 8'h00, row, col);
    use_idle  = 1'b0;
    mode_next = mode;
    row_next  = row;
    col_next  = col;
    if (item.operation == OpEnd) begin
      mode_next = ModeIdle;
      row_next  = PosWidth'(1);
      col_next  = '0;
      unique case (mode)
        ModeNum: begin
          own_emit = 1'b1;
          own_ev   = make_evt(EvDone, TkNat, 8'h00, row, col);
        end
        ModeIdent: begin
          own_emit = 1'b1;
          own_ev   = make_evt(EvDone, TkId, 8'h00, row, col);
        end
        ModeStr, ModeEsc: begin
          // unterminated string, a pending backslash is dropped
          own_emit = 1'b1;
          own_ev   = make_evt(EvDone, TkStr, 8'h00, row, col);
        end
        ModeColon: begin
          own_emit = 1'b1;
          own_ev   = make_evt(EvDone, TkColon, 8'h00, row, col);
        end
        default: begin
        end
      endcase
    end else begin
      unique case (mode)
        ModeHalt: begin
        end
        ModeNum: begin
          if (is_digit(c)) begin
            own_emit = 1'b1;
            own_ev   = make_evt(EvText, TkNat, c, row, col);
            col_next = col_inc;
          end else begin
            own_emit = 1'b1;
            own_ev   = make_evt(EvDone, TkNat, 8'h00, row, col);
            use_idle = 1'b1;
          end
        end
        ModeIdent: begin
          if (is_alpha(c) || is_digit(c)) begin
            own_emit = 1'b1;
            own_ev   = make_evt(EvText, TkId, c, row, col);
            col_next = col_inc;
          end else begin
            own_emit = 1'b1;
            own_ev   = make_evt(EvDone, TkId, 8'h00, row, col);
            use_idle = 1'b1;
          end
        end
        ModeStr: begin
          if (c == ChQuote) begin
            own_emit  = 1'b1;
            own_ev    = make_evt(EvDone, TkStr, 8'h00, row, col_inc);
            col_next  = col_inc;
            mode_next = ModeIdle;
          end else if (c == ChBslash) begin
            col_next  = col_inc;
            mode_next = ModeEsc;
          end else begin
            own_emit = 1'b1;
            own_ev   = make_evt(EvText, TkStr, c, row, col);
            col_next = col_inc;
          end
        end
        ModeEsc: begin
          own_emit  = 1'b1;
          own_ev    = make_evt(EvText, TkStr,
                               (c == ChLowN) ? ChLf : ((c == ChLowR) ? ChCr : c),
                               row, col);
          col_next  = col_inc;
          mode_next = ModeStr;
        end
        ModeColon: begin
          if (c == ChColon) begin
            own_emit  = 1'b1;
            own_ev    = make_evt(EvDone, TkDcolon, 8'h00, row, col_inc);
            col_next  = col_inc;
            mode_next = ModeIdle;
          end else begin
            own_emit = 1'b1;
            own_ev   = make_evt(EvDone, TkColon, 8'h00, row, col);
            use_idle = 1'b1;
          end
        end
        default: begin
          use_idle = 1'b1;
        end
      endcase
      if (use_idle) begin
        mode_next = idle_mode;
        row_next  = idle_row;
        col_next  = idle_col;
      end
    end
  end

  assign second_ok = use_idle && idle_emit;

  always_comb begin
    res        = '0;
    res.first  = own_ev;
    res.second = idle_ev;
    if (own_emit && second_ok) begin
      res.count       = 2'd2;
      res.second.last = 1'b1;
    end else if (own_emit) begin
      res.count      = 2'd1;
      res.first.last = 1'b1;
    end else if (second_ok) begin
      res.count      = 2'd1;
      res.first      = idle_ev;
      res.first.last = 1'b1;
    end
  end

endmodule

// ===== rtl/core/sct_result_fifo.sv =====
// ---------------------------------------------------------------------------
// sct_result_fifo
// small event queue, takes up to two events a cycle and gives one
// ---------------------------------------------------------------------------
module sct_result_fifo
  import sct_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  step_res_t                        wr_data,
  output logic [$clog2(FifoDepth+1)-1:0]   space,
  output logic                             evt_valid,
  input  logic                             evt_ready,
  output evt_item_t                        evt_item
);

  localparam int PtrW = $clog2(FifoDepth);
  localparam int CntW = $clog2(FifoDepth + 1);

  evt_item_t        mem [FifoDepth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic [CntW-1:0]  count_next;
  logic [1:0]       wr_num;
  logic             rd_en;

  assign wr_num    = wr_en ? wr_data.count : 2'd0;
  assign rd_en     = evt_valid && evt_ready;
  assign evt_valid = (count != '0);
  assign evt_item  = mem[rd_ptr];
  assign space     = CntW'(FifoDepth) - count;

  assign count_next = count + CntW'(wr_num) - CntW'(rd_en);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(wr_num);
      rd_ptr <= rd_ptr + PtrW'(rd_en);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_num != 2'd0) begin
      mem[wr_ptr] <= wr_data.first;
    end
    if (wr_num == 2'd2) begin
      mem[wr_ptr + PtrW'(1)] <= wr_data.second;
    end
  end

endmodule

// ===== rtl/core/source_char_tokenizer_core.sv =====
// ---------------------------------------------------------------------------
// source_char_tokenizer_core
// streaming lexer: one source character or end mark in, token events out
// ---------------------------------------------------------------------------
//  channel  direction  payload      handshake
//  char     in         char_item_t  char_valid / char_ready
//  evt      out        evt_item_t   evt_valid / evt_ready
//
//  an item is held in the input register, then one lexer step moves
//  it into a four-entry event queue: one item per cycle while the queue has
//  room, one event per cycle at the output while evt_ready is high
//  the step waits only while the queue lacks room for its events
//  reset empties both stages, mode idle, row 1, column 0
// ---------------------------------------------------------------------------
module source_char_tokenizer_core
  import sct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  char_item_t char_item,
  output logic       evt_valid,
  input  logic       evt_ready,
  output evt_item_t  evt_item
);

  localparam int CntW = $clog2(FifoDepth + 1);

  logic                in_full;
  char_item_t          in_item;
  logic                fire;
  logic [CntW-1:0]     space;

  mode_t               mode;
  mode_t               mode_next;
  logic [PosWidth-1:0] row;
  logic [PosWidth-1:0] row_next;
  logic [PosWidth-1:0] col;
  logic [PosWidth-1:0] col_next;
  step_res_t           res;

  sct_step u_step (
    .item      (in_item),
    .mode      (mode),
    .row       (row),
    .col       (col),
    .mode_next (mode_next),
    .row_next  (row_next),
    .col_next  (col_next),
    .res       (res)
  );

  // step only when the queue has room for every event of the item
  assign fire       = in_full && (CntW'(res.count) <= space);
  assign char_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      mode    <= ModeIdle;
      row     <= PosWidth'(1);
      col     <= '0;
    end else begin
      if (char_ready) begin
        in_full <= char_valid;
      end
      if (fire) begin
        mode <= mode_next;
        row  <= row_next;
        col  <= col_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (char_ready && char_valid) begin
      in_item <= char_item;
    end
  end

  sct_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (fire),
    .wr_data   (res),
    .space     (space),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt_item  (evt_item)
  );

endmodule

// ===== rtl/core/sct_checker.sv =====
// ---------------------------------------------------------------------------
// sct_checker
// port-level checks on the tokenizer event stream
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sct_checker
  import sct_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      evt_valid,
  input logic      evt_ready,
  input evt_item_t evt_item
);

  logic evt_stall;
  logic err_seen;
  logic err_ok;
  logic done_seen;
  logic nat_text;
  logic nat_ok;

  assign evt_stall = evt_valid && !evt_ready;
  assign err_seen  = evt_valid && (evt_item.event_kind == EvError);
  assign err_ok    = evt_item.last && (evt_item.token_kind == TkId);
  assign done_seen = evt_valid && (evt_item.event_kind == EvDone);
  assign nat_text  = evt_valid && (evt_item.event_kind == EvText)
                     && (evt_item.token_kind == TkNat);
  assign nat_ok    = (evt_item.text_char >= ChZero) && (evt_item.text_char <= ChNine);

  `SCT_ASSERT(a_evt_hold, evt_stall |=> evt_valid && $stable(evt_item), "event moved in stall")
  `SCT_ASSERT_IMP(a_err_last, err_seen, err_ok, "error event not last or kind not zero")
  `SCT_ASSERT_IMP(a_done_nochar, done_seen, evt_item.text_char == 8'h00, "done has a char")
  `SCT_ASSERT_IMP(a_nat_digit, nat_text, nat_ok, "number text not a digit")
  `SCT_ASSERT_IMP(a_row_nonzero, evt_valid, evt_item.line_number != '0, "row reads zero")

endmodule

bind source_char_tokenizer_core sct_checker u_sct_checker (.*);
